>>> hw/rtl/dpq_pkg.sv
// types and constants shared by the request queue modules
`default_nettype none

package dpq_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_MARK   = 2'd1;
   localparam logic [1:0] CMD_POP    = 2'd2;

   typedef enum logic [2:0] {
      ST_ADDED  = 3'd0,
      ST_MERGED = 3'd1,
      ST_FULL   = 3'd2,
      ST_MARKED = 3'd3,
      ST_POPPED = 3'd4,
      ST_EMPTY  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_SETW,
      S_COPY,
      S_PUT,
      S_PICK,
      S_PICKW,
      S_MARK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [15:0] col;
      logic [15:0] row;
      logic [31:0] layer;
   } key_type;

   typedef struct packed {
      logic    key_en;
      logic    flag_en;
      key_type key;
      logic    wanted;
   } wr_type;

   typedef struct packed {
      status_type  status;
      key_type     key;
      logic        wanted;
      logic [4:0]  fill;
   } result_type;

endpackage

`default_nettype wire

>>> hw/rtl/dedup_priority_request_queue_top.sv
// deduplicating priority queue of tile requests: top level with result register
//
// Request channel (req_*): one command per item: insert a tile key, mark all
// entries unwanted, or pop the frontmost wanted entry (front entry if none is
// wanted). Command code 3 behaves as pop. Response channel (rsp_*): exactly one
// item per request with status, popped key and wanted flag, and fill level.
// Entries live in one memory with a registered read port; a small sequencer
// walks it with one shared comparator, one entry per cycle.
// One item is in work at a time; the next is taken once the result has moved
// to the response register.
// Throughput is set by the scan and shift walks over the single memory port.
// Reset empties the queue (fill count zero) and drops any pending response.
// When the receiver stalls, the response register holds its item; a further
// request is still worked on and then waits until the register frees up.
`default_nettype none

module dedup_priority_request_queue_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_tile_col,
   input  wire logic [15:0] req_tile_row,
   input  wire logic [31:0] req_layer_id,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_out_col,
   output logic [15:0]      rsp_out_row,
   output logic [31:0]      rsp_out_layer,
   output logic             rsp_out_wanted,
   output logic [4:0]       rsp_fill_level
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   dpq_pkg::key_type    req_key;
   dpq_pkg::key_type    rd_key;
   logic                rd_wanted;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   dpq_pkg::wr_type     wr;
   logic                res_valid;
   dpq_pkg::result_type res;
   logic                res_free;
   logic                load;

   logic                rsp_valid_ff, rsp_valid_in;
   dpq_pkg::result_type rsp_data_ff, rsp_data_in;

   assign req_key.col   = req_tile_col;
   assign req_key.row   = req_tile_row;
   assign req_key.layer = req_layer_id;

   dpq_store #(
      .DEPTH(QUEUE_DEPTH)
   ) u_store (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .rd_key    (rd_key),
      .rd_wanted (rd_wanted),
      .wr_addr   (wr_addr),
      .wr        (wr)
   );

   dpq_ctrl #(
      .DEPTH(QUEUE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_key     (req_key),
      .rd_addr     (rd_addr),
      .rd_key      (rd_key),
      .rd_wanted   (rd_wanted),
      .wr_addr     (wr_addr),
      .wr          (wr),
      .res_valid   (res_valid),
      .res         (res),
      .res_free    (res_free)
   );

   assign res_free     = !rsp_valid_ff || rsp_ready;
   assign load         = res_valid && res_free;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = load ? res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_out_col    = rsp_data_ff.key.col;
   assign rsp_out_row    = rsp_data_ff.key.row;
   assign rsp_out_layer  = rsp_data_ff.key.layer;
   assign rsp_out_wanted = rsp_data_ff.wanted;
   assign rsp_fill_level = rsp_data_ff.fill;

endmodule

`default_nettype wire

>>> hw/rtl/dpq_store.sv
// entry memory: keys and wanted flags, one write and one registered read per cycle
`default_nettype none

module dpq_store #(
   parameter int DEPTH = 16,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic               clock,
   input  wire logic [IDX_W-1:0]   rd_addr,
   output dpq_pkg::key_type        rd_key,
   output logic                    rd_wanted,
   input  wire logic [IDX_W-1:0]   wr_addr,
   input  wire dpq_pkg::wr_type    wr
);

   dpq_pkg::key_type key_mem [DEPTH];
   logic             flag_mem [DEPTH];
   dpq_pkg::key_type rd_key_ff;
   logic             rd_wanted_ff;

   always_ff @(posedge clock) begin
      if (wr.key_en) begin
         key_mem[wr_addr] <= wr.key;
      end
      if (wr.flag_en) begin
         flag_mem[wr_addr] <= wr.wanted;
      end
      rd_key_ff    <= key_mem[rd_addr];
      rd_wanted_ff <= flag_mem[rd_addr];
   end

   assign rd_key    = rd_key_ff;
   assign rd_wanted = rd_wanted_ff;

endmodule

`default_nettype wire

>>> hw/rtl/dpq_ctrl.sv
// sequencer: key search with one shared comparator, entry shifting, mark and pop
`default_nettype none

module dpq_ctrl #(
   parameter int DEPTH = 16,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_command,
   input  wire dpq_pkg::key_type     req_key,
   output logic [IDX_W-1:0]          rd_addr,
   input  wire dpq_pkg::key_type     rd_key,
   input  wire logic                 rd_wanted,
   output logic [IDX_W-1:0]          wr_addr,
   output dpq_pkg::wr_type           wr,
   output logic                      res_valid,
   output dpq_pkg::result_type       res,
   input  wire logic                 res_free
);

   dpq_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]    pipe_idx_ff, pipe_idx_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [1:0]          cmd_ff, cmd_in;
   dpq_pkg::key_type    key_ff, key_in;
   dpq_pkg::status_type status_ff, status_in;
   dpq_pkg::key_type    res_key_ff, res_key_in;
   logic                res_wanted_ff, res_wanted_in;

   logic is_insert;
   logic match;
   logic found;
   logic walk_end;
   logic issue;

   assign is_insert = (cmd_ff == dpq_pkg::CMD_INSERT);
   // shared comparator: key equality for insert, wanted flag for pop
   assign match     = is_insert ? (rd_key == key_ff) : rd_wanted;
   assign found     = (state_ff == dpq_pkg::S_SCAN) && pipe_vld_ff && match;
   assign walk_end  = (rem_ff == '0) && !pipe_vld_ff;
   assign issue     = (rem_ff != '0) && !found;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= dpq_pkg::S_IDLE;
         count_ff    <= '0;
         pipe_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pipe_vld_ff <= pipe_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_idx_ff   <= pipe_idx_in;
      idx_ff        <= idx_in;
      rem_ff        <= rem_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      status_ff     <= status_in;
      res_key_ff    <= res_key_in;
      res_wanted_ff <= res_wanted_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dpq_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  dpq_pkg::CMD_INSERT: state_in = dpq_pkg::S_SCAN;
                  dpq_pkg::CMD_MARK:   state_in = dpq_pkg::S_MARK;
                  default: begin
                     state_in = (count_ff == '0) ? dpq_pkg::S_DONE : dpq_pkg::S_SCAN;
                  end
               endcase
            end
         end
         dpq_pkg::S_SCAN: begin
            if (found) begin
               state_in = is_insert ? dpq_pkg::S_SETW : dpq_pkg::S_PICK;
            end else if (walk_end) begin
               if (!is_insert) begin
                  state_in = dpq_pkg::S_PICK;
               end else if (count_ff == CNT_W'(DEPTH)) begin
                  state_in = dpq_pkg::S_DONE;
               end else begin
                  state_in = dpq_pkg::S_COPY;
               end
            end
         end
         dpq_pkg::S_SETW:  state_in = dpq_pkg::S_DONE;
         dpq_pkg::S_COPY: begin
            if (walk_end) begin
               state_in = is_insert ? dpq_pkg::S_PUT : dpq_pkg::S_DONE;
            end
         end
         dpq_pkg::S_PUT:   state_in = dpq_pkg::S_DONE;
         dpq_pkg::S_PICK:  state_in = dpq_pkg::S_PICKW;
         dpq_pkg::S_PICKW: state_in = dpq_pkg::S_COPY;
         dpq_pkg::S_MARK: begin
            if (rem_ff == '0) begin
               state_in = dpq_pkg::S_DONE;
            end
         end
         dpq_pkg::S_DONE: begin
            if (res_free) begin
               state_in = dpq_pkg::S_IDLE;
            end
         end
         default: state_in = dpq_pkg::S_IDLE;
      endcase
   end

   // datapath registers
   always_comb begin
      count_in      = count_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = idx_ff;
      idx_in        = idx_ff;
      rem_in        = rem_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      res_key_in    = res_key_ff;
      res_wanted_in = res_wanted_ff;
      case (state_ff)
         dpq_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_command;
               key_in        = req_key;
               idx_in        = '0;
               rem_in        = count_ff;
               res_key_in    = '0;
               res_wanted_in = 1'b0;
               status_in     = dpq_pkg::ST_EMPTY;
            end
         end
         dpq_pkg::S_SCAN: begin
            pipe_vld_in = issue;
            if (issue) begin
               idx_in = idx_ff + IDX_W'(1);
               rem_in = rem_ff - CNT_W'(1);
            end
            if (found) begin
               idx_in    = pipe_idx_ff;
               rem_in    = '0;
               status_in = dpq_pkg::ST_MERGED;
            end else if (walk_end) begin
               if (!is_insert) begin
                  idx_in = '0;
               end else if (count_ff == CNT_W'(DEPTH)) begin
                  status_in = dpq_pkg::ST_FULL;
               end else begin
                  // shift back, last entry first
                  idx_in = IDX_W'(count_ff - CNT_W'(1));
                  rem_in = count_ff;
               end
            end
         end
         dpq_pkg::S_SETW: ;
         dpq_pkg::S_COPY: begin
            pipe_vld_in = issue;
            if (issue) begin
               idx_in = is_insert ? (idx_ff - IDX_W'(1)) : (idx_ff + IDX_W'(1));
               rem_in = rem_ff - CNT_W'(1);
            end
            if (walk_end && !is_insert) begin
               count_in  = count_ff - CNT_W'(1);
               status_in = dpq_pkg::ST_POPPED;
            end
         end
         dpq_pkg::S_PUT: begin
            count_in  = count_ff + CNT_W'(1);
            status_in = dpq_pkg::ST_ADDED;
         end
         dpq_pkg::S_PICK: ;
         dpq_pkg::S_PICKW: begin
            res_key_in    = rd_key;
            res_wanted_in = rd_wanted;
            idx_in        = idx_ff + IDX_W'(1);
            rem_in        = count_ff - CNT_W'(1) - CNT_W'(idx_ff);
         end
         dpq_pkg::S_MARK: begin
            if (rem_ff != '0) begin
               idx_in = idx_ff + IDX_W'(1);
               rem_in = rem_ff - CNT_W'(1);
            end else begin
               status_in = dpq_pkg::ST_MARKED;
            end
         end
         dpq_pkg::S_DONE: ;
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      res_valid  = 1'b0;
      rd_addr    = idx_ff;
      wr_addr    = idx_ff;
      wr.key_en  = 1'b0;
      wr.flag_en = 1'b0;
      wr.key     = key_ff;
      wr.wanted  = 1'b1;
      res.status = status_ff;
      res.key    = res_key_ff;
      res.wanted = res_wanted_ff;
      res.fill   = 5'(count_ff);
      case (state_ff)
         dpq_pkg::S_IDLE: req_ready = 1'b1;
         dpq_pkg::S_SETW: wr.flag_en = 1'b1;
         dpq_pkg::S_COPY: begin
            wr_addr    = is_insert ? (pipe_idx_ff + IDX_W'(1)) : (pipe_idx_ff - IDX_W'(1));
            wr.key_en  = pipe_vld_ff;
            wr.flag_en = pipe_vld_ff;
            wr.key     = rd_key;
            wr.wanted  = rd_wanted;
         end
         dpq_pkg::S_PUT: begin
            wr_addr    = '0;
            wr.key_en  = 1'b1;
            wr.flag_en = 1'b1;
         end
         dpq_pkg::S_MARK: begin
            wr.flag_en = (rem_ff != '0);
            wr.wanted  = 1'b0;
         end
         dpq_pkg::S_DONE: res_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

>>> verif/dedup_priority_request_queue_top_tb.sv
// testbench for the deduplicating tile request queue: directed and random commands, scoreboard check
`default_nettype none

module dedup_priority_request_queue_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dpq_pkg::*;

   localparam int         QUEUE_DEPTH   = 16;
   localparam int         POOL_SIZE     = 20;
   localparam int         RANDOM_ITEMS  = 630;
   localparam logic [1:0] CMD_ALIAS_POP = 2'd3;

   class tile_queue_scoreboard;
      key_type    held_key[QUEUE_DEPTH];
      bit         held_wanted[QUEUE_DEPTH];
      int         held_count;
      result_type due[$];
      int         errors;
      int         accepted;
      int         checked;
      int         status_tally[6];

      function int pending();
         return due.size();
      endfunction

      // work out the response of one accepted command and queue it
      function void note_request(logic [1:0] cmd, key_type k);
         result_type r;
         int         i;
         int         hit;
         int         pick;
         r = '0;
         accepted++;
         if (cmd == CMD_INSERT) begin
            hit = -1;
            for (i = 0; i < held_count; i++) begin
               if (hit < 0 && held_key[i] == k) hit = i;
            end
            if (hit >= 0) begin
               held_wanted[hit] = 1'b1;
               r.status = ST_MERGED;
            end else if (held_count >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (i = held_count; i > 0; i--) begin
                  held_key[i]    = held_key[i-1];
                  held_wanted[i] = held_wanted[i-1];
               end
               held_key[0]    = k;
               held_wanted[0] = 1'b1;
               held_count++;
               r.status = ST_ADDED;
            end
         end else if (cmd == CMD_MARK) begin
            for (i = 0; i < held_count; i++) held_wanted[i] = 1'b0;
            r.status = ST_MARKED;
         end else if (held_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            pick = -1;
            for (i = 0; i < held_count; i++) begin
               if (pick < 0 && held_wanted[i]) pick = i;
            end
            if (pick < 0) pick = 0;
            r.key    = held_key[pick];
            r.wanted = held_wanted[pick];
            for (i = pick; i + 1 < held_count; i++) begin
               held_key[i]    = held_key[i+1];
               held_wanted[i] = held_wanted[i+1];
            end
            held_count--;
            r.status = ST_POPPED;
         end
         r.fill = 5'(held_count);
         due.push_back(r);
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (due.size() == 0) begin
            $error("unexpected response item: status %0d", got.status);
            errors++;
            return;
         end
         want = due.pop_front();
         checked++;
         status_tally[want.status]++;
         if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.key.col != want.key.col) begin
            $error("out_col: expected %0h, got %0h", want.key.col, got.key.col);
            errors++;
         end
         if (got.key.row != want.key.row) begin
            $error("out_row: expected %0h, got %0h", want.key.row, got.key.row);
            errors++;
         end
         if (got.key.layer != want.key.layer) begin
            $error("out_layer: expected %0h, got %0h", want.key.layer, got.key.layer);
            errors++;
         end
         if (got.wanted != want.wanted) begin
            $error("out_wanted: expected %0d, got %0d", want.wanted, got.wanted);
            errors++;
         end
         if (got.fill != want.fill) begin
            $error("fill_level: expected %0d, got %0d", want.fill, got.fill);
            errors++;
         end
      endfunction
   endclass

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command    = CMD_INSERT;
   logic [15:0] req_tile_col   = '0;
   logic [15:0] req_tile_row   = '0;
   logic [31:0] req_layer_id   = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_out_col;
   logic [15:0] rsp_out_row;
   logic [31:0] rsp_out_layer;
   logic        rsp_out_wanted;
   logic [4:0]  rsp_fill_level;

   int                   rcv_idle_pct = 81;
   key_type              key_pool[POOL_SIZE];
   tile_queue_scoreboard board = new;

   dedup_priority_request_queue_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_tile_col   (req_tile_col),
      .req_tile_row   (req_tile_row),
      .req_layer_id   (req_layer_id),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_layer  (rsp_out_layer),
      .rsp_out_wanted (rsp_out_wanted),
      .rsp_fill_level (rsp_fill_level)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_response(result_type'({rsp_status, rsp_out_col, rsp_out_row,
                                            rsp_out_layer, rsp_out_wanted,
                                            rsp_fill_level}));
      end
   end

   function automatic key_type make_key(logic [15:0] c, logic [15:0] r, logic [31:0] l);
      key_type k;
      k.col   = c;
      k.row   = r;
      k.layer = l;
      return k;
   endfunction

   function automatic key_type random_key();
      return make_key(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                      $urandom);
   endfunction

   function automatic key_type pick_key();
      if ($urandom_range(99) < 70) return key_pool[$urandom_range(POOL_SIZE - 1)];
      return random_key();
   endfunction

   task automatic send_request(logic [1:0] cmd, key_type k);
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_tile_col <= k.col;
      req_tile_row <= k.row;
      req_layer_id <= k.layer;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(cmd, k);
   endtask

   task automatic sender_gap(int pct);
      while ($urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic run_random(int count, int gap_pct);
      int         n;
      int         pct;
      int         insert_w;
      logic [1:0] cmd;
      insert_w = 50;
      for (n = 0; n < count; n++) begin
         if (n % 40 == 0) insert_w = $urandom_range(25, 80);
         if (n % 250 == 125) wait_drained();
         sender_gap(gap_pct);
         pct = $urandom_range(99);
         if (pct < 3) cmd = CMD_ALIAS_POP;
         else if (pct < 10) cmd = CMD_MARK;
         else if (pct < 10 + insert_w) cmd = CMD_INSERT;
         else cmd = CMD_POP;
         send_request(cmd, (cmd == CMD_INSERT) ? pick_key() : random_key());
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = make_key(16'($urandom_range(3) * 16'h5555),
                                16'($urandom_range(3) * 16'h5555),
                                (i % 5 == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(3)));
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue corners
      send_request(CMD_POP, make_key(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
      send_request(CMD_MARK, make_key(16'h0, 16'h0, 32'h0));
      // fill to the limit, field extremes first
      send_request(CMD_INSERT, make_key(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
      send_request(CMD_INSERT, make_key(16'h0, 16'h0, 32'h0));
      for (i = 2; i < QUEUE_DEPTH; i++) begin
         sender_gap(37);
         send_request(CMD_INSERT, make_key(16'(i * 4099), 16'(~i), 32'hA5A5_0000 | i));
      end
      send_request(CMD_INSERT, make_key(16'h8000, 16'h0001, 32'h8000_0000));
      send_request(CMD_INSERT, make_key(16'h0, 16'h0, 32'h0));
      send_request(CMD_MARK, random_key());
      send_request(CMD_POP, random_key());
      send_request(CMD_INSERT, make_key(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
      send_request(CMD_ALIAS_POP, random_key());
      send_request(CMD_POP, random_key());
      wait_drained();

      run_random(RANDOM_ITEMS, 37);
      wait_drained();
      rcv_idle_pct = 37;
      run_random(RANDOM_ITEMS, 81);
      wait_drained();
      rcv_idle_pct = 0;
      run_random(RANDOM_ITEMS, 0);

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("%0d commands sent, %0d responses checked", board.accepted, board.checked);
      $display("added %0d, merged %0d, full %0d, marked %0d, popped %0d, empty %0d",
               board.status_tally[ST_ADDED], board.status_tally[ST_MERGED],
               board.status_tally[ST_FULL], board.status_tally[ST_MARKED],
               board.status_tally[ST_POPPED], board.status_tally[ST_EMPTY]);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("dedup_priority_request_queue_top_tb: done, clean");
      end else begin
         $display("dedup_priority_request_queue_top_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #(8_000_000);
      $display("dedup_priority_request_queue_top_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
